>>> rtl/kli_pkg.sv
// kli_pkg: shared codes, defaults and control types for the keyed list core
// no dependencies; imported by kli_ctrl and keyed_list_insert_delete_core
package kli_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned DepthDef       = 16;
  localparam int unsigned KeyBitsDef     = 32;
  localparam int unsigned PayloadBitsDef = 32;

  // command codes
  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  // insert mode codes (the spare code behaves as tail)
  localparam logic [1:0] ModeHead  = 2'd0;
  localparam logic [1:0] ModeOrder = 2'd1;
  localparam logic [1:0] ModeTail  = 2'd2;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;
  localparam logic [1:0] StatusRange    = 2'd3;

  // result control from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } res_ctl_t;

endpackage

>>> rtl/kli_ram.sv
// kli_ram: generic single write port, single read port memory
// registered read data; no dependencies
module kli_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kli_ctrl.sv
// kli_ctrl: command sequencer, scans and shifts list entries in the entry ram
// depends on kli_pkg; drives the kli_ram ports through the top level
module kli_ctrl #(
  parameter int unsigned Depth       = kli_pkg::DepthDef,
  parameter int unsigned KeyBits     = kli_pkg::KeyBitsDef,
  parameter int unsigned PayloadBits = kli_pkg::PayloadBitsDef,
  localparam int unsigned Aw = $clog2(Depth),
  localparam int unsigned Lw = $clog2(Depth + 1),
  localparam int unsigned Ew = KeyBits + PayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              mode_i,
  // command transaction
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic [KeyBits-1:0]      key_i,
  input  logic [PayloadBits-1:0]  payload_i,
  input  logic [Aw-1:0]           position_i,
  // entry ram
  output logic                    ram_we_o,
  output logic [Aw-1:0]           ram_waddr_o,
  output logic [Ew-1:0]           ram_wdata_o,
  output logic [Aw-1:0]           ram_raddr_o,
  input  logic [Ew-1:0]           ram_rdata_i,
  // result
  output kli_pkg::res_ctl_t       res_ctl_o,
  output logic [Lw-1:0]           res_length_o,
  output logic [KeyBits-1:0]      res_key_o,
  output logic [PayloadBits-1:0]  res_payload_o,
  input  logic                    res_ready_i
);
  import kli_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScRd   = 4'd1;
  localparam logic [3:0] SScChk  = 4'd2;
  localparam logic [3:0] SShRd   = 4'd3;
  localparam logic [3:0] SShWr   = 4'd4;
  localparam logic [3:0] SWrite  = 4'd5;
  localparam logic [3:0] SRdWait = 4'd6;
  localparam logic [3:0] SDone   = 4'd7;

  logic [3:0]             state_q, state_d;
  logic [Lw-1:0]          count_q, count_d;
  logic [Aw-1:0]          idx_q, idx_d;
  logic [Aw-1:0]          pos_q, pos_d;
  logic [1:0]             status_q, status_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [KeyBits-1:0]     key_q, key_d;
  logic [PayloadBits-1:0] pay_q, pay_d;
  logic [KeyBits-1:0]     rkey_q, rkey_d;
  logic [PayloadBits-1:0] rpay_q, rpay_d;

  logic                   accept;
  logic                   idx_last;
  logic [KeyBits-1:0]     ram_key;
  logic [PayloadBits-1:0] ram_pay;

  assign accept   = in_valid_i && (state_q == SIdle);
  assign idx_last = ((Lw'(idx_q) + Lw'(1)) == count_q);
  assign ram_key  = ram_rdata_i[Ew-1:PayloadBits];
  assign ram_pay  = ram_rdata_i[PayloadBits-1:0];

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    status_d = status_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    pay_d    = pay_q;
    rkey_d   = rkey_q;
    rpay_d   = rpay_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_d    = cmd_i;
          key_d    = key_i;
          pay_d    = payload_i;
          status_d = StatusOk;
          rkey_d   = '0;
          rpay_d   = '0;
          state_d  = SDone;
          unique case (cmd_i)
            CmdInsert: begin
              if (count_q == Lw'(Depth)) begin
                status_d = StatusFull;
              end else if (mode_i == ModeHead) begin
                pos_d = '0;
                if (count_q == '0) begin
                  state_d = SWrite;
                end else begin
                  idx_d   = Aw'(count_q - Lw'(1));
                  state_d = SShRd;
                end
              end else if (mode_i == ModeOrder) begin
                pos_d = '0;
                idx_d = '0;
                state_d = (count_q == '0) ? SWrite : SScRd;
              end else begin
                pos_d   = Aw'(count_q);
                state_d = SWrite;
              end
            end
            CmdDelete: begin
              if (count_q == '0) begin
                status_d = StatusNotFound;
              end else begin
                idx_d   = '0;
                state_d = SScRd;
              end
            end
            CmdRead: begin
              if (Lw'(position_i) >= count_q) begin
                status_d = StatusRange;
              end else begin
                state_d = SRdWait;
              end
            end
            default: begin
              state_d = SDone;
            end
          endcase
        end
      end
      SScRd: begin
        state_d = SScChk;
      end
      SScChk: begin
        if (cmd_q == CmdInsert) begin
          // key order: stop at the first entry not less than the new key
          if ($signed(ram_key) >= $signed(key_q)) begin
            pos_d   = idx_q;
            idx_d   = Aw'(count_q - Lw'(1));
            state_d = SShRd;
          end else if (idx_last) begin
            pos_d   = Aw'(count_q);
            state_d = SWrite;
          end else begin
            idx_d   = idx_q + Aw'(1);
            state_d = SScRd;
          end
        end else begin
          // delete: first matching key from the head
          if (ram_key == key_q) begin
            if (idx_last) begin
              count_d = count_q - Lw'(1);
              state_d = SDone;
            end else begin
              idx_d   = idx_q + Aw'(1);
              state_d = SShRd;
            end
          end else if (idx_last) begin
            status_d = StatusNotFound;
            state_d  = SDone;
          end else begin
            idx_d   = idx_q + Aw'(1);
            state_d = SScRd;
          end
        end
      end
      SShRd: begin
        state_d = SShWr;
      end
      SShWr: begin
        if (cmd_q == CmdInsert) begin
          if (idx_q == pos_q) begin
            state_d = SWrite;
          end else begin
            idx_d   = idx_q - Aw'(1);
            state_d = SShRd;
          end
        end else begin
          if (idx_last) begin
            count_d = count_q - Lw'(1);
            state_d = SDone;
          end else begin
            idx_d   = idx_q + Aw'(1);
            state_d = SShRd;
          end
        end
      end
      SWrite: begin
        count_d = count_q + Lw'(1);
        state_d = SDone;
      end
      SRdWait: begin
        rkey_d  = ram_key;
        rpay_d  = ram_pay;
        state_d = SDone;
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    rkey_q   <= rkey_d;
    rpay_q   <= rpay_d;
  end

  // ram access: reads for scan, shift and position read, writes for shift and store
  always_comb begin
    ram_raddr_o = (state_q == SIdle) ? position_i : idx_q;
    ram_we_o    = (state_q == SShWr) || (state_q == SWrite);
    ram_wdata_o = (state_q == SWrite) ? {key_q, pay_q} : ram_rdata_i;
    if (state_q == SWrite) begin
      ram_waddr_o = pos_q;
    end else if (cmd_q == CmdInsert) begin
      ram_waddr_o = idx_q + Aw'(1);
    end else begin
      ram_waddr_o = idx_q - Aw'(1);
    end
  end

  assign in_stall_o       = (state_q != SIdle);
  assign res_ctl_o.valid  = (state_q == SDone);
  assign res_ctl_o.status = status_q;
  assign res_length_o     = count_q;
  assign res_key_o        = rkey_q;
  assign res_payload_o    = rpay_q;

endmodule

>>> rtl/keyed_list_insert_delete_core.sv
// per command: a read waits on the registered ram read; an insert scans in key order
//   mode, shifts the entries behind its slot up and stores; a delete scans from the head
//   for the key and shifts the later entries down; full insert, empty delete, range read
//   and spare command go straight to the result, which then waits on output stalls
// one transaction in flight; the scan and shift loop runs over the entry ram's single read port
// reset: list empty, insert mode tail; ram contents are not cleared, no clearing pass
// depends on kli_pkg, kli_ctrl and kli_ram
module keyed_list_insert_delete_core #(
  parameter int unsigned DEPTH        = kli_pkg::DepthDef,
  parameter int unsigned KEY_BITS     = kli_pkg::KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = kli_pkg::PayloadBitsDef,
  localparam int unsigned Aw = $clog2(DEPTH),
  localparam int unsigned Lw = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_data_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic signed [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,
  input  logic [Aw-1:0]                  position_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [Lw-1:0]                  length_o,
  output logic signed [KEY_BITS-1:0]     read_key_o,
  output logic [PAYLOAD_BITS-1:0]        read_payload_o
);
  import kli_pkg::*;

  localparam int unsigned Ew = KEY_BITS + PAYLOAD_BITS;

  logic [1:0]              mode_q;
  logic                    ram_we;
  logic [Aw-1:0]           ram_waddr;
  logic [Ew-1:0]           ram_wdata;
  logic [Aw-1:0]           ram_raddr;
  logic [Ew-1:0]           ram_rdata;
  res_ctl_t                res_ctl;
  logic [Lw-1:0]           res_length;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic                    res_ready;
  logic                    out_valid_q;
  logic [1:0]              status_q;
  logic [Lw-1:0]           length_q;
  logic [KEY_BITS-1:0]     read_key_q;
  logic [PAYLOAD_BITS-1:0] read_payload_q;

  // insert mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeTail;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // command sequencer
  kli_ctrl #(
    .Depth      (DEPTH),
    .KeyBits    (KEY_BITS),
    .PayloadBits(PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .payload_i    (payload_i),
    .position_i   (position_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .res_ctl_o    (res_ctl),
    .res_length_o (res_length),
    .res_key_o    (res_key),
    .res_payload_o(res_payload),
    .res_ready_i  (res_ready)
  );

  // entry ram, key above payload
  kli_ram #(
    .Width(Ew),
    .Depth(DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register, loaded when empty or being taken
  assign res_ready = res_ctl.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) begin
      status_q       <= res_ctl.status;
      length_q       <= res_length;
      read_key_q     <= res_key;
      read_payload_q <= res_payload;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign length_o       = length_q;
  assign read_key_o     = read_key_q;
  assign read_payload_o = read_payload_q;

`ifndef ASSERT_OFF
  // the reported length never exceeds the list capacity
  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= Lw'(DEPTH)))
    else $error("length beyond capacity");

  // a full report only comes from a full list
  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StatusFull)) |-> (length_o == Lw'(DEPTH)))
    else $error("full status with list not full");

  // read fields are zero on any transaction that did not succeed
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StatusOk)) |-> ((read_key_o == '0) && (read_payload_o == '0)))
    else $error("read data on failed transaction");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_ready)
    else $error("held result overwritten");
`endif

endmodule

>>> tb/sv/keyed_list_insert_delete_checker.sv
// checker for the keyed list core: watches the config, command and result channels,
// keeps its own copy of the list, predicts each result and compares it
// depends on kli_pkg for command, mode and status codes and default sizes
`timescale 1ns / 100ps

module keyed_list_insert_delete_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  input  logic                                     cfg_ready_i,
  input  logic [1:0]                               cfg_data_i,
  input  logic                                     in_valid_i,
  input  logic                                     in_stall_i,
  input  logic [1:0]                               cmd_i,
  input  logic signed [kli_pkg::KeyBitsDef-1:0]    key_i,
  input  logic [kli_pkg::PayloadBitsDef-1:0]       payload_i,
  input  logic [$clog2(kli_pkg::DepthDef)-1:0]     position_i,
  input  logic                                     out_valid_i,
  input  logic                                     out_stall_i,
  input  logic [1:0]                               status_i,
  input  logic [$clog2(kli_pkg::DepthDef+1)-1:0]   length_i,
  input  logic signed [kli_pkg::KeyBitsDef-1:0]    read_key_i,
  input  logic [kli_pkg::PayloadBitsDef-1:0]       read_payload_i,
  output int                                       pending_o,
  output int                                       fail_count_o
);
  import kli_pkg::*;

  localparam int Depth = DepthDef;
  localparam int KeyW  = KeyBitsDef;
  localparam int PayW  = PayloadBitsDef;
  localparam int LenW  = $clog2(DepthDef + 1);
  localparam int PosW  = $clog2(DepthDef);

  typedef struct packed {
    logic [1:0]             status;
    logic [LenW-1:0]        length;
    logic signed [KeyW-1:0] read_key;
    logic [PayW-1:0]        read_payload;
  } list_result_t;

  // mirror of the list, head first
  logic signed [KeyW-1:0] key_mirror [Depth];
  logic [PayW-1:0]        payload_mirror [Depth];
  int                     entries_held;
  logic [1:0]             insert_mode;

  list_result_t expected_results [$];
  int                     result_index;

  // apply one command to the mirror and return the result it gives
  function automatic list_result_t apply_list_command(input logic [1:0] op,
                                                      input logic signed [KeyW-1:0] k,
                                                      input logic [PayW-1:0] d,
                                                      input logic [PosW-1:0] pos);
    list_result_t r;
    int           slot;
    int           i;
    r        = '0;
    r.status = StatusOk;
    case (op)
      CmdInsert: begin
        if (entries_held >= Depth) begin
          r.status = StatusFull;
        end else begin
          case (insert_mode)
            ModeHead: slot = 0;
            ModeOrder: begin
              // goes in front of the first key not below its own, so before equals
              slot = 0;
              while (slot < entries_held && key_mirror[slot] < k) slot++;
            end
            default: slot = entries_held;
          endcase
          for (i = entries_held; i > slot; i--) begin
            key_mirror[i]     = key_mirror[i-1];
            payload_mirror[i] = payload_mirror[i-1];
          end
          key_mirror[slot]     = k;
          payload_mirror[slot] = d;
          entries_held++;
        end
      end
      CmdDelete: begin
        slot = 0;
        while (slot < entries_held && key_mirror[slot] != k) slot++;
        if (slot >= entries_held) begin
          r.status = StatusNotFound;
        end else begin
          for (i = slot; i + 1 < entries_held; i++) begin
            key_mirror[i]     = key_mirror[i+1];
            payload_mirror[i] = payload_mirror[i+1];
          end
          entries_held--;
        end
      end
      CmdRead: begin
        if (int'(pos) >= entries_held) begin
          r.status = StatusRange;
        end else begin
          r.read_key     = key_mirror[pos];
          r.read_payload = payload_mirror[pos];
        end
      end
      default: ;
    endcase
    r.length = entries_held[LenW-1:0];
    return r;
  endfunction

  // result check first, then prediction of a newly accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      entries_held = 0;
      insert_mode  = ModeTail;
      expected_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
      result_index = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) insert_mode = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, length_i, read_key_i, read_payload_i};
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result %0d arrived with nothing expected: status %0d length %0d",
                     result_index, got.status, got.length);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.length !== want.length ||
              got.read_key !== want.read_key || got.read_payload !== want.read_payload) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result %0d mismatch (expected/actual): status %0d/%0d ",
                        "length %0d/%0d read_key %h/%h read_payload %h/%h"},
                       result_index, want.status, got.status, want.length, got.length,
                       want.read_key, got.read_key, want.read_payload, got.read_payload);
          end
        end
        result_index++;
      end

      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_list_command(cmd_i, key_i, payload_i, position_i));

      pending_o = expected_results.size();
    end
  end

endmodule

>>> tb/sv/keyed_list_insert_delete_core_test.sv
// top of the keyed list core testbench: clock, reset, stimulus and verdict
// depends on kli_pkg, the core and keyed_list_insert_delete_checker
`timescale 1ns / 100ps

module keyed_list_insert_delete_core_test;
  import kli_pkg::*;

  localparam int KeyW = KeyBitsDef;
  localparam int PayW = PayloadBitsDef;
  localparam int PosW = $clog2(DepthDef);
  localparam int LenW = $clog2(DepthDef + 1);

  // spare codes with no name in the package
  localparam logic [1:0] CmdSpare  = 2'd3;
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam int PhaseItems = 210;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_data = ModeTail;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             cmd = CmdRead;
  logic signed [KeyW-1:0] key = '0;
  logic [PayW-1:0]        payload = '0;
  logic [PosW-1:0]        position = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             status;
  logic [LenW-1:0]        length;
  logic signed [KeyW-1:0] read_key;
  logic [PayW-1:0]        read_payload;

  int                     pending;
  int                     fail_count;
  bit                     tx_calm = 1'b0;
  bit                     rx_calm = 1'b0;

  // small key pool so deletes hit and equal keys meet in key order
  logic signed [KeyW-1:0] key_pool [8] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1,
                                           32'sd1, 32'sd5, 32'sd100, -32'sd100};
  logic [1:0]             phase_modes [8] = '{ModeHead, ModeOrder, ModeSpare, ModeTail,
                                             ModeOrder, ModeHead, ModeTail, ModeOrder};
  logic signed [KeyW-1:0] fill_keys [16] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1,
                                             -32'sd1, 32'sd1, 32'sh12345678, -32'sh1000,
                                             32'sd7, 32'sd7, 32'sd64, -32'sd64,
                                             32'sd2, 32'sd3, 32'sd4, 32'sh7ffffffe};

  always #10 clk = ~clk;

  keyed_list_insert_delete_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .key_i          (key),
    .payload_i      (payload),
    .position_i     (position),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .length_o       (length),
    .read_key_o     (read_key),
    .read_payload_o (read_payload)
  );

  keyed_list_insert_delete_checker list_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .key_i          (key),
    .payload_i      (payload),
    .position_i     (position),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .length_i       (length),
    .read_key_i     (read_key),
    .read_payload_i (read_payload),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= !rx_calm && ($urandom_range(99) < 38);
  end

  // one command transaction, entered and left at a falling edge
  task automatic send_command(input logic [1:0] c, input logic signed [KeyW-1:0] k,
                              input logic [PayW-1:0] d, input logic [PosW-1:0] p);
    int gap;
    gap = 0;
    if (!tx_calm)
      while ($urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    key      <= k;
    payload  <= d;
    position <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait for every expected result
  task automatic wait_list_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_insert_mode(input logic [1:0] m);
    wait_list_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    if ($urandom_range(99) < 70) return key_pool[3'($urandom_range(7))];
    return $urandom;
  endfunction

  // timeout guard
  initial begin
    #60_000_000;
    $display("keyed_list_insert_delete_core regression: fail");
    $finish;
  end

  initial begin
    int               roll;
    int               ins_weight;
    logic [1:0]       c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases under the reset mode (tail)
    send_command(CmdRead, 32'sd0, '0, '0);
    send_command(CmdDelete, 32'sd5, '0, '0);
    send_command(CmdSpare, 32'sh7fffffff, '1, '1);

    // key order fill with extremes and equal keys, then one insert too many
    write_insert_mode(ModeOrder);
    for (int i = 0; i < 16; i++)
      send_command(CmdInsert, fill_keys[i],
                   (i == 0) ? '1 : (i == 1) ? '0 : PayW'($urandom), '0);
    send_command(CmdInsert, 32'sd9, 32'hdeadbeef, '0);
    send_command(CmdRead, '0, '0, 4'd15);
    send_command(CmdRead, '0, '0, 4'd0);
    send_command(CmdDelete, 32'sd99, '0, '0);
    send_command(CmdDelete, 32'sh80000000, '0, '0);

    // random phases: insert heavy first half, delete heavy second half
    for (int ph = 0; ph < 8; ph++) begin
      write_insert_mode(phase_modes[ph]);
      tx_calm = (ph == 3);
      rx_calm = (ph == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 5 && n == PhaseItems / 2) wait_list_idle();
        ins_weight = (n < PhaseItems / 2) ? 55 : 20;
        roll = $urandom_range(99);
        if (roll < ins_weight) c = CmdInsert;
        else if (roll < 75) c = CmdDelete;
        else if (roll < 97) c = CmdRead;
        else c = CmdSpare;
        send_command(c, pick_key(), PayW'($urandom), PosW'($urandom_range(15)));
      end
    end

    wait_list_idle();
    repeat (80) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("keyed_list_insert_delete_core regression: pass");
    end else begin
      $display("keyed_list_insert_delete_core regression: fail");
    end
    $finish;
  end

endmodule
